// ----- design/stdz_pkg.sv -----
// ----------------------------------------------------------------------------
// stdz_pkg: shared types and constants of the stick/trigger deadzone block
// Sample width, full-scale value, register indexes, mode codes and the
// packed transaction types of the input and result channels.
// ----------------------------------------------------------------------------
package stdz_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DEAD_BITS   = 15;
  localparam int CFG_IDX_W   = 1;

  // 1.0 in sample units
  localparam logic [SAMPLE_BITS-2:0] FULL_SCALE = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STICK_DEAD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DEAD = 1'b1;

  // mode codes
  localparam logic MODE_STICK   = 1'b0;
  localparam logic MODE_TRIGGER = 1'b1;

  typedef struct packed {
    logic                           mode;
    logic signed [SAMPLE_BITS-1:0]  x_sample;
    logic signed [SAMPLE_BITS-1:0]  y_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  x_out;
    logic signed [SAMPLE_BITS-1:0]  y_out;
  } out_item_t;

endpackage

// ----- design/stdz_isqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// stdz_isqrt_pipe: pipelined integer square root
// Digit-by-digit restoring root, two radicand bits per registered stage,
// RW/2 stages. A sideband word and a valid bit travel with each operand.
// ----------------------------------------------------------------------------
module stdz_isqrt_pipe #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [RW-1:0]   in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int H = RW / 2;

  logic [H-1:0]  vld_r;
  logic [RW-1:0] rad_r  [H];
  logic [H+1:0]  rem_r  [H];
  logic [H-1:0]  root_r [H];
  logic [SW-1:0] side_r [H];

  for (genvar k = 0; k < H; k++) begin : g_step
    logic          cur_vld;
    logic [RW-1:0] cur_rad;
    logic [H+1:0]  cur_rem;
    logic [H-1:0]  cur_root;
    logic [SW-1:0] cur_side;
    logic [H+1:0]  rem_sh;
    logic [H+1:0]  trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rad  = in_rad;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_vld  = vld_r[k-1];
      assign cur_rad  = rad_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_side = side_r[k-1];
    end

    // bring down two bits and try root*4+1
    assign rem_sh = {cur_rem[H-1:0], cur_rad[RW-1:RW-2]};
    assign trial  = {cur_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= {cur_rad[RW-3:0], 2'b00};
      rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[k] <= {cur_root[H-2:0], ge};
      side_r[k] <= cur_side;
    end
  end

  assign out_valid = vld_r[H-1];
  assign out_root  = root_r[H-1];
  assign out_side  = side_r[H-1];

endmodule

// ----- design/stdz_div_pipe.sv -----
// ----------------------------------------------------------------------------
// stdz_div_pipe: pipelined unsigned restoring divider
// One quotient bit per registered stage, QW stages. The caller guarantees
// that the quotient fits QW bits, so NW - QW equals DW and the top part of
// the numerator is already below the divisor.
// ----------------------------------------------------------------------------
module stdz_div_pipe #(
  parameter int NW = 30,
  parameter int DW = 15,
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          cur_vld;
    logic [DW-1:0] cur_rem;
    logic [QW-1:0] cur_low;
    logic [QW-1:0] cur_quo;
    logic [DW-1:0] cur_den;
    logic [SW-1:0] cur_side;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = DW'(in_num >> QW);
      assign cur_low  = in_num[QW-1:0];
      assign cur_quo  = '0;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_vld  = vld_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_low  = low_r[k-1];
      assign cur_quo  = quo_r[k-1];
      assign cur_den  = den_r[k-1];
      assign cur_side = side_r[k-1];
    end

    // shift in the next numerator bit and subtract if it fits
    assign rem_sh = {cur_rem, cur_low[QW-1]};
    assign diff   = rem_sh - {1'b0, cur_den};
    assign ge     = (rem_sh >= {1'b0, cur_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      low_r[k]  <= {cur_low[QW-2:0], 1'b0};
      quo_r[k]  <= {cur_quo[QW-2:0], ge};
      den_r[k]  <= cur_den;
      side_r[k] <= cur_side;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ----- design/stick_trigger_deadzone.sv -----
// ----------------------------------------------------------------------------
// stick_trigger_deadzone: radial scaled deadzone for gamepad samples
// Pipelined conditioner of stick pairs and trigger values.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start; the transaction is taken at every
//   edge where start is high and busy is low. busy stays low, so a new sample
//   may enter in every cycle.
//   Output: each result shows on out_data for one cycle with out_valid high.
//   Results leave in input order; the receiver cannot stall. Throughput is
//   one sample per cycle. The pipeline holds the root unit (SAMPLE_BITS
//   stages) and a chain of two dividers (SAMPLE_BITS-1 stages each), one
//   result bit per stage, plus five pipeline registers.
//   Config: cfg_we with cfg_index selects the stick or trigger deadzone;
//   write only while no transaction is in flight.
//   Reset: synchronous rst_n clears all valid bits and both deadzones.
// ----------------------------------------------------------------------------
module stick_trigger_deadzone (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  stdz_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  output stdz_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [stdz_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stdz_pkg::DEAD_BITS-1:0]        cfg_data
);

  import stdz_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int FS_W  = SB - 1;
  localparam int SQ_W  = 2 * SB;
  localparam int N1_W  = 2 * SB - 2;
  localparam int P_W   = 2 * SB - 1;
  localparam int CMP_W = (SB > DEAD_BITS) ? SB : DEAD_BITS;
  localparam int SQ_SW = 1 + 2 * SB;
  localparam int D1_SW = 2 + 3 * SB;

  // configuration registers
  logic [DEAD_BITS-1:0] stick_dead_r;
  logic [DEAD_BITS-1:0] trigger_dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_dead_r   <= '0;
      trigger_dead_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STICK_DEAD:   stick_dead_r   <= cfg_data;
        REG_TRIGGER_DEAD: trigger_dead_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: capture and take magnitudes
  logic                 s1_vld_r;
  logic                 s1_mode_r;
  logic signed [SB-1:0] s1_x_r;
  logic signed [SB-1:0] s1_y_r;
  logic [SB-1:0]        s1_ax_r;
  logic [SB-1:0]        s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= in_data.mode;
    s1_x_r    <= in_data.x_sample;
    s1_y_r    <= in_data.y_sample;
    s1_ax_r   <= in_data.x_sample[SB-1] ? (~in_data.x_sample + 1'b1) : in_data.x_sample;
    s1_ay_r   <= in_data.y_sample[SB-1] ? (~in_data.y_sample + 1'b1) : in_data.y_sample;
  end

  // stage 2: squares
  logic                 s2_vld_r;
  logic                 s2_mode_r;
  logic signed [SB-1:0] s2_x_r;
  logic signed [SB-1:0] s2_y_r;
  logic [SQ_W-1:0]      s2_sqx_r;
  logic [SQ_W-1:0]      s2_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s2_sqx_r  <= SQ_W'(s1_ax_r) * SQ_W'(s1_ax_r);
    s2_sqy_r  <= SQ_W'(s1_ay_r) * SQ_W'(s1_ay_r);
  end

  // length of the pair
  logic             sq_vld;
  logic [SB-1:0]    sq_root;
  logic [SQ_SW-1:0] sq_side;

  stdz_isqrt_pipe #(
    .RW (SQ_W),
    .SW (SQ_SW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_rad    (s2_sqx_r + s2_sqy_r),
    .in_side   ({s2_mode_r, s2_x_r, s2_y_r}),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: deadzone test, clamp and rescale numerator
  logic                 q_mode;
  logic signed [SB-1:0] q_x;
  logic signed [SB-1:0] q_y;
  logic [SB-1:0]        q_level;
  logic [DEAD_BITS-1:0] q_dead;
  logic                 q_active;
  logic [FS_W-1:0]      q_clamp;
  logic [FS_W-1:0]      q_dead_n;
  logic [FS_W-1:0]      q_diff;

  assign {q_mode, q_x, q_y} = sq_side;

  always_comb begin
    if (q_mode == MODE_STICK) begin
      q_level = sq_root;
      q_dead  = stick_dead_r;
    end else begin
      q_level = q_x[SB-1] ? '0 : q_x;
      q_dead  = trigger_dead_r;
    end
    q_active = (CMP_W'(q_level) > CMP_W'(q_dead)) && (CMP_W'(q_dead) < CMP_W'(FULL_SCALE));
    q_clamp  = (q_level > {1'b0, FULL_SCALE}) ? FULL_SCALE : q_level[FS_W-1:0];
    q_dead_n = FS_W'(q_dead);
    q_diff   = q_clamp - q_dead_n;
  end

  logic                 s4_vld_r;
  logic                 s4_active_r;
  logic                 s4_mode_r;
  logic signed [SB-1:0] s4_x_r;
  logic signed [SB-1:0] s4_y_r;
  logic [SB-1:0]        s4_len_r;
  logic [N1_W-1:0]      s4_numer_r;
  logic [FS_W-1:0]      s4_denom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= sq_vld;
    end
  end

  // multiply by full scale as (diff << FS_W) - diff
  always_ff @(posedge clk) begin
    s4_active_r <= q_active;
    s4_mode_r   <= q_mode;
    s4_x_r      <= q_x;
    s4_y_r      <= q_y;
    s4_len_r    <= sq_root;
    if (q_active) begin
      s4_numer_r <= {q_diff, FS_W'(0)} - N1_W'(q_diff);
      s4_denom_r <= FULL_SCALE - q_dead_n;
    end else begin
      s4_numer_r <= '0;
      s4_denom_r <= FS_W'(1);
    end
  end

  // rescaled length
  logic             d1_vld;
  logic [FS_W-1:0]  d1_quo;
  logic [D1_SW-1:0] d1_side;

  stdz_div_pipe #(
    .NW (N1_W),
    .DW (FS_W),
    .QW (FS_W),
    .SW (D1_SW)
  ) u_div_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_vld_r),
    .in_num    (s4_numer_r),
    .in_den    (s4_denom_r),
    .in_side   ({s4_active_r, s4_mode_r, s4_x_r, s4_y_r, s4_len_r}),
    .out_valid (d1_vld),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // stage 5: direction products
  logic                 e_active;
  logic                 e_mode;
  logic signed [SB-1:0] e_x;
  logic signed [SB-1:0] e_y;
  logic [SB-1:0]        e_len;
  logic [SB-1:0]        e_opx;
  logic [SB-1:0]        e_opy;
  logic [SB-1:0]        e_den;

  assign {e_active, e_mode, e_x, e_y, e_len} = d1_side;

  always_comb begin
    if (!e_active) begin
      e_opx = '0;
      e_opy = '0;
      e_den = SB'(1);
    end else if (e_mode == MODE_TRIGGER) begin
      e_opx = SB'(1);
      e_opy = '0;
      e_den = SB'(1);
    end else begin
      e_opx = e_x[SB-1] ? (~e_x + 1'b1) : e_x;
      e_opy = e_y[SB-1] ? (~e_y + 1'b1) : e_y;
      e_den = e_len;
    end
  end

  logic             s5_vld_r;
  logic             s5_active_r;
  logic             s5_sx_r;
  logic             s5_sy_r;
  logic [P_W-1:0]   s5_px_r;
  logic [P_W-1:0]   s5_py_r;
  logic [SB-1:0]    s5_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_active_r <= e_active;
    s5_sx_r     <= e_x[SB-1];
    s5_sy_r     <= e_y[SB-1];
    s5_px_r     <= P_W'(e_opx) * P_W'(d1_quo);
    s5_py_r     <= P_W'(e_opy) * P_W'(d1_quo);
    s5_den_r    <= e_den;
  end

  // divide both components by the true length (by one for triggers and inside the deadzone)
  logic            dx_vld;
  logic [FS_W-1:0] dx_quo;
  logic [1:0]      dx_side;
  logic            dy_vld;
  logic [FS_W-1:0] dy_quo;
  logic            dy_side;

  stdz_div_pipe #(
    .NW (P_W),
    .DW (SB),
    .QW (FS_W),
    .SW (2)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_vld_r),
    .in_num    (s5_px_r),
    .in_den    (s5_den_r),
    .in_side   ({s5_active_r, s5_sx_r}),
    .out_valid (dx_vld),
    .out_quo   (dx_quo),
    .out_side  (dx_side)
  );

  stdz_div_pipe #(
    .NW (P_W),
    .DW (SB),
    .QW (FS_W),
    .SW (1)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_vld_r),
    .in_num    (s5_py_r),
    .in_den    (s5_den_r),
    .in_side   (s5_sy_r),
    .out_valid (dy_vld),
    .out_quo   (dy_quo),
    .out_side  (dy_side)
  );

  // output stage: restore signs, zero inside the deadzone
  logic [SB-1:0] f_magx;
  logic [SB-1:0] f_magy;
  logic          out_vld_r;
  logic [SB-1:0] out_x_r;
  logic [SB-1:0] out_y_r;

  assign f_magx = {1'b0, dx_quo};
  assign f_magy = {1'b0, dy_quo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!dx_side[1]) begin
      out_x_r <= '0;
      out_y_r <= '0;
    end else begin
      out_x_r <= dx_side[0] ? (~f_magx + 1'b1) : f_magx;
      out_y_r <= dy_side ? (~f_magy + 1'b1) : f_magy;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_data.x_out = out_x_r;
  assign out_data.y_out = out_y_r;

  // checks
  a_scale_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && s4_active_r |-> s4_denom_r != '0)
    else $error("rescale divisor is zero for an active sample");

  a_len_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s5_vld_r && s5_active_r |-> s5_den_r != '0)
    else $error("length divisor is zero for an active sample");

  a_dividers_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    dx_vld == dy_vld)
    else $error("x and y dividers out of step");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x_r != {1'b1, FS_W'(0)} && out_y_r != {1'b1, FS_W'(0)})
    else $error("result outside full scale");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the stick/trigger deadzone conditioner
// Drives directed stick and trigger samples, then random bursts, under several deadzone
// settings and checks every result against a behavioral deadzone predictor.
// ----------------------------------------------------------------------------
module tb;
  import stdz_pkg::*;

  localparam int LATENCY = 3 * SAMPLE_BITS + 3;
  localparam longint FS = (1 << (SAMPLE_BITS - 1)) - 1;

  // Scoreboard: predicts conditioned samples and checks the DUT results
  class deadzone_sb;
    out_item_t pending[$];
    logic [DEAD_BITS-1:0] stick_dz;
    logic [DEAD_BITS-1:0] trig_dz;
    int n_err;
    int n_in;
    int n_out;

    function new();
      stick_dz = '0;
      trig_dz = '0;
      n_err = 0;
      n_in = 0;
      n_out = 0;
    endfunction

    function longint root_floor(longint n);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n) r = r + (64'sd1 << b);
      end
      return r;
    endfunction

    function longint rescale(longint lvl, longint dz);
      longint c;
      c = (lvl > FS) ? FS : lvl;
      return (c - dz) * FS / (FS - dz);
    endfunction

    // Compute the conditioned sample for one accepted transaction
    function void note_input(in_item_t it);
      longint x, y, xo, yo, dz, len, s;
      out_item_t r;
      x = it.x_sample;
      y = it.y_sample;
      xo = 0;
      yo = 0;
      if (it.mode == MODE_STICK) begin
        dz = stick_dz;
        len = root_floor(x * x + y * y);
        if (len > dz && dz < FS) begin
          s = rescale(len, dz);
          xo = x * s / len;
          yo = y * s / len;
        end
      end else begin
        dz = trig_dz;
        if (x > dz && dz < FS) xo = rescale(x, dz);
      end
      r.x_out = xo[SAMPLE_BITS-1:0];
      r.y_out = yo[SAMPLE_BITS-1:0];
      pending.push_back(r);
      n_in++;
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t exp_r;
      n_out++;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result x=%0d y=%0d", got.x_out, got.y_out);
        return;
      end
      exp_r = pending.pop_front();
      if (got.x_out !== exp_r.x_out || got.y_out !== exp_r.y_out) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                   exp_r.x_out, exp_r.y_out, got.x_out, got.y_out);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DEAD_BITS-1:0] cfg_data;
  deadzone_sb sb;

  stick_trigger_deadzone u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check results and note accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_input(in_data);
    end
  end

  // Write one deadzone register while the pipeline is empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEAD_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STICK_DEAD) sb.stick_dz = val;
    else sb.trig_dz = val;
    @(posedge clk);
  endtask

  // Hold one transaction until accepted, then drop start unless keep is set
  task automatic send(logic m, logic [SAMPLE_BITS-1:0] x, logic [SAMPLE_BITS-1:0] y,
                      bit keep);
    start <= 1'b1;
    in_data <= '{mode: m, x_sample: x, y_sample: y};
    do @(posedge clk); while (busy);
    if (!keep) start <= 1'b0;
  endtask

  // Wait for all results, then let the pipeline drain
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      3: return 16'($urandom_range(0, 40));
      4: return -16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send bursts; hold start across a burst boundary that has no gap
  task automatic random_phase(int n);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 20);
      if (burst > left) burst = left;
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      for (int i = 0; i < burst; i++)
        send(1'($urandom), rand_sample(), rand_sample(),
             (i != burst - 1) || (gap == 0 && left > burst));
      left -= burst;
      repeat (gap) @(posedge clk);
    end
  endtask

  logic [DEAD_BITS-1:0] dz_set[6] = '{15'd0, 15'h7FFF, 15'd8000, 15'd1, 15'h7FFE, 15'd0};

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_STICK_DEAD;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero length, overlong diagonal, negative trigger
    write_reg(REG_STICK_DEAD, 15'd4000);
    write_reg(REG_TRIGGER_DEAD, 15'd3000);
    send(MODE_STICK, 16'd0, 16'd0, 1);
    send(MODE_STICK, 16'h7FFF, 16'h7FFF, 1);
    send(MODE_STICK, 16'h8000, 16'h8000, 1);
    send(MODE_STICK, 16'h8000, 16'd0, 1);
    send(MODE_STICK, 16'd4000, 16'd0, 1);
    send(MODE_STICK, 16'd4001, 16'd0, 1);
    send(MODE_STICK, 16'hFFFF, 16'h7FFF, 1);
    send(MODE_STICK, 16'd1000, 16'hF000, 1);
    send(MODE_TRIGGER, 16'h8000, 16'h7FFF, 1);
    send(MODE_TRIGGER, 16'hFFFF, 16'hFFFF, 1);
    send(MODE_TRIGGER, 16'd3000, 16'd0, 1);
    send(MODE_TRIGGER, 16'd3001, 16'd0, 1);
    send(MODE_TRIGGER, 16'h7FFF, 16'h5555, 1);
    send(MODE_TRIGGER, 16'd20000, 16'hAAAA, 0);
    drain();
    write_reg(REG_STICK_DEAD, 15'h7FFF);
    write_reg(REG_TRIGGER_DEAD, 15'h7FFF);
    send(MODE_STICK, 16'h7FFF, 16'd0, 1);
    send(MODE_TRIGGER, 16'h7FFF, 16'd0, 0);
    drain();

    // random phases across deadzone settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_STICK_DEAD, dz_set[p]);
      write_reg(REG_TRIGGER_DEAD, (p == 5) ? 15'($urandom) : dz_set[5 - p]);
      random_phase(175);
      drain();
    end

    $display("covered %0d samples over several deadzone settings, %0d results checked",
             sb.n_in, sb.n_out);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("[stick_trigger_deadzone] OK");
    end else begin
      $display("mismatches: %0d, missing results: %0d", sb.n_err, sb.pending.size());
      $display("[stick_trigger_deadzone] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[stick_trigger_deadzone] ERROR");
    $finish;
  end

endmodule
